@@ hdl/ers_pkg.sv @@
// Shared constants, codes and cell control types for the elevator request scheduler.
package ers_pkg;

	localparam int FLOORS   = 4;
	localparam int FL_W     = (FLOORS > 1) ? $clog2(FLOORS) : 1;
	localparam int FIELD_W  = 2;

	typedef enum logic [1:0] {
		KIND_HALL_UP = 2'd0,
		KIND_HALL_DN = 2'd1,
		KIND_CABIN   = 2'd2,
		KIND_NONE    = 2'd3
	} order_kind_t;

	typedef enum logic [1:0] {
		DIR_UP   = 2'd0,
		DIR_DOWN = 2'd1,
		DIR_IDLE = 2'd2,
		DIR_RSVD = 2'd3
	} travel_dir_t;

	// Per-cell update of the pending bits.
	typedef struct packed {
		logic load;
		logic clr;
		logic set_up;
		logic set_dn;
	} cell_upd_t;

	// Scan token control, common to every cell.
	typedef struct packed {
		logic load_tok;
		logic shift;
		logic dir_up;
		logic sel_up;
	} tok_ctl_t;

endpackage

@@ hdl/ers_if.sv @@
// Request and response channel interfaces of the elevator request scheduler.
interface ers_req_if;
	logic       valid;
	logic       ready;
	logic       order_valid;
	logic [1:0] order_floor;
	logic [1:0] order_kind;
	logic       floor_clear_valid;
	logic [1:0] floor_to_clear;
	logic       clear_every_floor;
	logic [1:0] last_floor;
	logic       car_above;
	logic [1:0] travel_dir;

	modport source (
		output valid, order_valid, order_floor, order_kind, floor_clear_valid,
			floor_to_clear, clear_every_floor, last_floor, car_above, travel_dir,
		input  ready
	);
	modport sink (
		input  valid, order_valid, order_floor, order_kind, floor_clear_valid,
			floor_to_clear, clear_every_floor, last_floor, car_above, travel_dir,
		output ready
	);
endinterface

interface ers_rsp_if;
	logic       valid;
	logic       ready;
	logic       target_found;
	logic [1:0] target_floor;

	modport source (output valid, target_found, target_floor, input ready);
	modport sink   (input valid, target_found, target_floor, output ready);
endinterface

@@ hdl/ers_cell.sv @@
// One floor cell: pending up/down bits and the scan token stage.
module ers_cell
	import ers_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_upd_t upd,
	input  tok_ctl_t  ctl,
	input  logic      inject,
	input  logic      tok_below,
	input  logic      tok_above,
	output logic      tok,
	output logic      hit
);

	logic up_q;
	logic dn_q;
	logic tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= 1'b0;
			dn_q <= 1'b0;
		end else if (upd.load) begin
			up_q <= (up_q & ~upd.clr) | upd.set_up;
			dn_q <= (dn_q & ~upd.clr) | upd.set_dn;
		end
	end

	// Take the token from the neighbor behind the sweep direction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.load_tok) begin
			tok_q <= inject;
		end else if (ctl.shift) begin
			tok_q <= ctl.dir_up ? tok_below : tok_above;
		end
	end

	assign tok = tok_q;
	assign hit = tok_q & (ctl.sel_up ? up_q : dn_q);

endmodule

@@ hdl/elevator_request_scheduler_top.sv @@
// Top level of the elevator request scheduler: item control, order decode and cell row.
// Flow: accept, update the pending bits in S_UPD, then up to three scan passes, each
// placing or skipping the token in S_START and then walking it floor by floor in
// S_RUN until a hit or the end of the pass; the result then sits in an output
// register until taken.
// Throughput: one item at a time; the next item is taken once the result is taken.
// Reset: arst_n clears all pending bits, the scan token and the output valid at once.
module elevator_request_scheduler_top
	import ers_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	ers_req_if.sink       req,
	ers_rsp_if.source     rsp
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_UPD   = 4'b0010,
		S_START = 4'b0100,
		S_RUN   = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		PASS_FIRST  = 2'd0,
		PASS_SECOND = 2'd1,
		PASS_THIRD  = 2'd2,
		PASS_NONE   = 2'd3
	} pass_t;

	state_t      state_q;
	pass_t       pass_q;
	logic [FL_W-1:0] pos_q;

	// Item fields, held for the whole scan.
	logic        ord_valid_q;
	logic [1:0]  ord_floor_q;
	logic [1:0]  ord_kind_q;
	logic        fclr_valid_q;
	logic [1:0]  fclr_floor_q;
	logic        clr_all_q;
	logic [1:0]  last_q;
	logic        above_q;
	logic [1:0]  dir_q;

	logic        out_valid_q;
	logic        found_q;
	logic [1:0]  floor_q;

	cell_upd_t   upd   [FLOORS];
	tok_ctl_t    ctl;
	logic [FLOORS-1:0] tok;
	logic [FLOORS-1:0] hit;
	logic [FLOORS-1:0] inject;
	logic        any_hit;

	logic        scan_on;
	logic        p_empty;
	logic        p_up;
	logic        p_sel_up;
	logic [FL_W-1:0] p_start;
	logic [FL_W-1:0] p_end;

	logic        req_acc;

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign req_acc   = req.valid && req.ready;

	assign rsp.valid        = out_valid_q;
	assign rsp.target_found = found_q;
	assign rsp.target_floor = floor_q;

	// Order decode: clear all, then clear one floor, then place the order.
	always_comb begin
		for (int i = 0; i < FLOORS; i++) begin
			upd[i].load   = (state_q == S_UPD);
			upd[i].clr    = clr_all_q || (fclr_valid_q && int'(fclr_floor_q) == i);
			upd[i].set_up = 1'b0;
			upd[i].set_dn = 1'b0;
			if (ord_valid_q && int'(ord_floor_q) == i) begin
				if (i == FLOORS - 1) begin
					upd[i].set_up = 1'b1;
				end else if (i == 0) begin
					upd[i].set_dn = 1'b1;
				end else begin
					case (ord_kind_q)
						KIND_HALL_UP: upd[i].set_up = 1'b1;
						KIND_HALL_DN: upd[i].set_dn = 1'b1;
						KIND_CABIN: begin
							if (int'(last_q) == i) begin
								upd[i].set_up = !above_q;
								upd[i].set_dn = above_q;
							end else if (i > int'(last_q)) begin
								upd[i].set_up = 1'b1;
							end else begin
								upd[i].set_dn = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	// Range, direction and set of the current scan pass.
	always_comb begin
		int l;
		int s;
		int e;
		l        = int'(last_q);
		s        = 0;
		e        = FLOORS - 1;
		p_empty  = 1'b0;
		p_up     = 1'b1;
		p_sel_up = 1'b1;
		scan_on  = (dir_q == DIR_UP) || (dir_q == DIR_DOWN);
		case (pass_q)
			PASS_FIRST: begin
				if (dir_q == DIR_UP) begin
					// Up bits above the last floor, sweeping up.
					p_empty = (l >= FLOORS - 1);
					s       = l + 1;
				end else begin
					// Down bits below the last floor, sweeping down.
					p_up     = 1'b0;
					p_sel_up = 1'b0;
					p_empty  = (l == 0);
					s        = ((l < FLOORS) ? l : FLOORS) - 1;
					e        = 0;
				end
			end
			PASS_SECOND: begin
				if (dir_q == DIR_UP) begin
					p_up     = 1'b0;
					p_sel_up = 1'b0;
					s        = FLOORS - 1;
					e        = 0;
				end
			end
			PASS_THIRD: begin
				if (dir_q == DIR_UP) begin
					e = (l < FLOORS - 1) ? l : FLOORS - 1;
				end else begin
					p_up     = 1'b0;
					p_sel_up = 1'b0;
					p_empty  = (l > FLOORS - 1);
					s        = FLOORS - 1;
					e        = l;
				end
			end
			default: p_empty = 1'b1;
		endcase
		if (p_empty) begin
			s = 0;
			e = 0;
		end
		p_start = FL_W'(s);
		p_end   = FL_W'(e);
	end

	assign any_hit = |hit;

	always_comb begin
		ctl.load_tok = (state_q == S_START) && scan_on && !p_empty;
		ctl.shift    = (state_q == S_RUN) && !any_hit && (pos_q != p_end);
		ctl.dir_up   = p_up;
		ctl.sel_up   = p_sel_up;
		for (int i = 0; i < FLOORS; i++) begin
			inject[i] = (int'(p_start) == i);
		end
	end

	// Row of cells; the token walks one floor per cycle between neighbors.
	for (genvar g = 0; g < FLOORS; g++) begin : g_cell
		logic below;
		logic above;
		if (g == 0) begin : g_bot
			assign below = 1'b0;
		end else begin : g_mid_b
			assign below = tok[g-1];
		end
		if (g == FLOORS - 1) begin : g_top
			assign above = 1'b0;
		end else begin : g_mid_a
			assign above = tok[g+1];
		end
		ers_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.upd       (upd[g]),
			.ctl       (ctl),
			.inject    (inject[g]),
			.tok_below (below),
			.tok_above (above),
			.tok       (tok[g]),
			.hit       (hit[g])
		);
	end

	// Latch the item on accept.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			ord_valid_q  <= req.order_valid;
			ord_floor_q  <= req.order_floor;
			ord_kind_q   <= req.order_kind;
			fclr_valid_q <= req.floor_clear_valid;
			fclr_floor_q <= req.floor_to_clear;
			clr_all_q    <= req.clear_every_floor;
			last_q       <= req.last_floor;
			above_q      <= req.car_above;
			dir_q        <= req.travel_dir;
		end
	end

	// Sequencer: update, then passes until a hit or the last one ends; no scan if not up or down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= PASS_FIRST;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			floor_q     <= '0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					pass_q  <= PASS_FIRST;
					state_q <= S_START;
				end
				S_START: begin
					if (!scan_on || (p_empty && pass_q == PASS_THIRD)) begin
						out_valid_q <= 1'b1;
						found_q     <= 1'b0;
						floor_q     <= '0;
						state_q     <= S_IDLE;
					end else if (p_empty) begin
						pass_q <= pass_t'(pass_q + 2'd1);
					end else begin
						pos_q   <= p_start;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (any_hit) begin
						out_valid_q <= 1'b1;
						found_q     <= 1'b1;
						floor_q     <= FIELD_W'(pos_q);
						state_q     <= S_IDLE;
					end else if (pos_q == p_end) begin
						if (pass_q == PASS_THIRD) begin
							out_valid_q <= 1'b1;
							found_q     <= 1'b0;
							floor_q     <= '0;
							state_q     <= S_IDLE;
						end else begin
							pass_q  <= pass_t'(pass_q + 2'd1);
							state_q <= S_START;
						end
					end else begin
						// Advance the position with the token.
						pos_q <= p_up ? pos_q + 1'b1 : pos_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one scan token in the cell row");

	a_tok_at_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> tok[pos_q])
		else $error("scan token not at the tracked floor");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (floor_q == '0))
		else $error("target floor nonzero without a target");

	a_acc_upd: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == S_UPD))
		else $error("accepted item did not start the pending-bit update");

	a_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && any_hit) |=> (out_valid_q && found_q))
		else $error("hit in the cell row did not produce a result");

endmodule

@@ tb/ers_checker.sv @@
// Scoreboard for the elevator request scheduler: tracks pending calls and checks every target.
`timescale 1ns / 100ps

module ers_checker
	import ers_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ers_req_if   req,
	ers_rsp_if   rsp,
	output int   fail_count,
	output int   pending_count,
	output int   checked_count,
	output int   found_count
);

	typedef struct packed {
		logic       found;
		logic [1:0] floor;
	} target_t;

	logic [FLOORS-1:0] up_calls;
	logic [FLOORS-1:0] down_calls;
	target_t           target_q[$];
	int                fails;
	int                checked;
	int                founds;

	// Apply one request to the call sets and pick the next stop.
	function automatic target_t next_stop(
		input logic        ov,
		input logic [1:0]  ofl,
		input order_kind_t kind,
		input logic        fcv,
		input logic [1:0]  fcf,
		input logic        cef,
		input logic [1:0]  last,
		input logic        above,
		input travel_dir_t dir
	);
		target_t t;
		int      i;
		int      lf;
		t  = '0;
		lf = int'(last);
		if (cef) begin
			up_calls   = '0;
			down_calls = '0;
		end
		if (fcv) begin
			up_calls[fcf]   = 1'b0;
			down_calls[fcf] = 1'b0;
		end
		if (ov) begin
			if (ofl == FLOORS - 1)
				up_calls[ofl] = 1'b1;
			else if (ofl == 0)
				down_calls[ofl] = 1'b1;
			else begin
				case (kind)
					KIND_HALL_UP: up_calls[ofl] = 1'b1;
					KIND_HALL_DN: down_calls[ofl] = 1'b1;
					KIND_CABIN: begin
						if (ofl == last) begin
							if (above)
								down_calls[ofl] = 1'b1;
							else
								up_calls[ofl] = 1'b1;
						end else if (ofl > last)
							up_calls[ofl] = 1'b1;
						else
							down_calls[ofl] = 1'b1;
					end
					default: ;
				endcase
			end
		end
		case (dir)
			DIR_UP: begin
				for (i = lf + 1; i < FLOORS && !t.found; i++)
					if (up_calls[i]) begin t.found = 1'b1; t.floor = 2'(i); end
				for (i = FLOORS - 1; i >= 0 && !t.found; i--)
					if (down_calls[i]) begin t.found = 1'b1; t.floor = 2'(i); end
				for (i = 0; i <= lf && i < FLOORS && !t.found; i++)
					if (up_calls[i]) begin t.found = 1'b1; t.floor = 2'(i); end
			end
			DIR_DOWN: begin
				for (i = lf - 1; i >= 0 && !t.found; i--)
					if (down_calls[i]) begin t.found = 1'b1; t.floor = 2'(i); end
				for (i = 0; i < FLOORS && !t.found; i++)
					if (up_calls[i]) begin t.found = 1'b1; t.floor = 2'(i); end
				for (i = FLOORS - 1; i >= lf && !t.found; i--)
					if (down_calls[i]) begin t.found = 1'b1; t.floor = 2'(i); end
			end
			default: ;
		endcase
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		target_t exp_t;
		if (!arst_n) begin
			up_calls   = '0;
			down_calls = '0;
			target_q.delete();
			fails         = 0;
			checked       = 0;
			founds        = 0;
			fail_count    <= 0;
			pending_count <= 0;
			checked_count <= 0;
			found_count   <= 0;
		end else begin
			// Check the result first, then queue the expected target of any request taken.
			if (rsp.valid && rsp.ready) begin
				if (target_q.size() == 0) begin
					$error("unexpected target: found=%0d floor=%0d",
						rsp.target_found, rsp.target_floor);
					fails++;
				end else begin
					exp_t = target_q.pop_front();
					checked++;
					if (exp_t.found)
						founds++;
					if (rsp.target_found !== exp_t.found) begin
						$error("target_found: expected %0d, got %0d",
							exp_t.found, rsp.target_found);
						fails++;
					end
					if (rsp.target_floor !== exp_t.floor) begin
						$error("target_floor: expected %0d, got %0d",
							exp_t.floor, rsp.target_floor);
						fails++;
					end
				end
			end
			if (req.valid && req.ready)
				target_q.push_back(next_stop(req.order_valid, req.order_floor,
					order_kind_t'(req.order_kind), req.floor_clear_valid,
					req.floor_to_clear, req.clear_every_floor, req.last_floor,
					req.car_above, travel_dir_t'(req.travel_dir)));
			fail_count    <= fails;
			pending_count <= target_q.size();
			checked_count <= checked;
			found_count   <= founds;
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Top of the elevator request scheduler testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
	import ers_pkg::*;

	// Cycles without any handshake before the run is declared hung. The slowest legal
	// stretch is a long sender gap plus a full scan plus a long receiver stall,
	// well under IDLE_LIMIT.
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_CALLS = 1200;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic        ov;
		logic [1:0]  ofl;
		order_kind_t kind;
		logic        fcv;
		logic [1:0]  fcf;
		logic        cef;
		logic [1:0]  last;
		logic        above;
		travel_dir_t dir;
	} floor_call_t;

	logic clk;
	logic arst_n;
	ers_req_if req_ch ();
	ers_rsp_if rsp_ch ();

	int fail_count;
	int pending_count;
	int checked_count;
	int found_count;
	int sent_count;
	int idle_cycles;
	bit steady;

	elevator_request_scheduler_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ers_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count),
		.found_count   (found_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic floor_call_t mk_call(
		input logic        ov,
		input logic [1:0]  ofl,
		input order_kind_t kind,
		input logic        fcv,
		input logic [1:0]  fcf,
		input logic        cef,
		input logic [1:0]  last,
		input logic        above,
		input travel_dir_t dir
	);
		floor_call_t c;
		c.ov    = ov;
		c.ofl   = ofl;
		c.kind  = kind;
		c.fcv   = fcv;
		c.fcf   = fcf;
		c.cef   = cef;
		c.last  = last;
		c.above = above;
		c.dir   = dir;
		return c;
	endfunction

	// Orders are frequent and full clears rare, so the call sets fill up and the
	// scans have real work; idle and reserved directions stay in as noise.
	function automatic floor_call_t random_call();
		floor_call_t c;
		int          r;
		c.ov    = ($urandom_range(0, 3) != 0);
		c.ofl   = 2'($urandom_range(0, 3));
		c.kind  = order_kind_t'(($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2));
		c.fcv   = ($urandom_range(0, 3) == 0);
		c.fcf   = 2'($urandom_range(0, 3));
		c.cef   = ($urandom_range(0, 19) == 0);
		c.last  = 2'($urandom_range(0, 3));
		c.above = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 9);
		if (r < 4)
			c.dir = DIR_UP;
		else if (r < 8)
			c.dir = DIR_DOWN;
		else if (r == 8)
			c.dir = DIR_IDLE;
		else
			c.dir = DIR_RSVD;
		return c;
	endfunction

	// Present one item and hold it until the block takes it. Valid stays high on
	// return so that a back-to-back item never toggles it within one step.
	task automatic issue_call(input floor_call_t c);
		req_ch.valid             <= 1'b1;
		req_ch.order_valid       <= c.ov;
		req_ch.order_floor       <= c.ofl;
		req_ch.order_kind        <= c.kind;
		req_ch.floor_clear_valid <= c.fcv;
		req_ch.floor_to_clear    <= c.fcf;
		req_ch.clear_every_floor <= c.cef;
		req_ch.last_floor        <= c.last;
		req_ch.car_above         <= c.above;
		req_ch.travel_dir        <= c.dir;
		do @(posedge clk); while (!req_ch.ready);
		sent_count++;
	endtask

	// Drop valid for a gap; a zero gap keeps the next item back to back.
	task automatic hold_off(input int n);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected target has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	// Receiver: ready in bursts, stalls of random length between them, none while steady.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : pick_gap();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Watchdog: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
			$display("tb_top: FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		floor_call_t directed[$];
		int          n;
		arst_n                   <= 1'b0;
		steady                   <= 1'b0;
		sent_count                = 0;
		req_ch.valid             <= 1'b0;
		req_ch.order_valid       <= 1'b0;
		req_ch.order_floor       <= '0;
		req_ch.order_kind        <= KIND_HALL_UP;
		req_ch.floor_clear_valid <= 1'b0;
		req_ch.floor_to_clear    <= '0;
		req_ch.clear_every_floor <= 1'b0;
		req_ch.last_floor        <= '0;
		req_ch.car_above         <= 1'b0;
		req_ch.travel_dir        <= DIR_UP;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: empty sets, every order kind, top and bottom floor rules,
		// cabin calls on every side of the last floor, idle and reserved direction,
		// clear ordering and full scans from each last floor.
		// empty sets: no target in either direction
		directed.push_back(mk_call(0, 0, KIND_HALL_UP, 0, 0, 0, 0, 0, DIR_UP));
		directed.push_back(mk_call(0, 0, KIND_HALL_UP, 0, 0, 0, 3, 1, DIR_DOWN));
		// hall up and hall down on middle floors
		directed.push_back(mk_call(1, 1, KIND_HALL_UP, 0, 0, 0, 0, 0, DIR_UP));
		directed.push_back(mk_call(1, 2, KIND_HALL_DN, 0, 0, 0, 0, 0, DIR_DOWN));
		// top floor always lands in the up set, bottom floor in the down set
		directed.push_back(mk_call(1, 3, KIND_HALL_DN, 0, 0, 0, 3, 0, DIR_UP));
		directed.push_back(mk_call(1, 0, KIND_HALL_UP, 0, 0, 0, 3, 0, DIR_DOWN));
		// start clean, then cabin calls relative to the last floor
		directed.push_back(mk_call(0, 0, KIND_HALL_UP, 0, 0, 1, 0, 0, DIR_UP));
		directed.push_back(mk_call(1, 2, KIND_CABIN, 0, 0, 0, 2, 1, DIR_DOWN));
		directed.push_back(mk_call(1, 1, KIND_CABIN, 0, 0, 0, 1, 0, DIR_UP));
		directed.push_back(mk_call(1, 2, KIND_CABIN, 0, 0, 0, 1, 0, DIR_UP));
		directed.push_back(mk_call(1, 1, KIND_CABIN, 1, 2, 0, 2, 1, DIR_DOWN));
		// empty order kind: only the top and bottom floor rules take effect
		directed.push_back(mk_call(1, 1, KIND_NONE, 0, 0, 1, 0, 0, DIR_UP));
		directed.push_back(mk_call(1, 3, KIND_NONE, 0, 0, 0, 0, 0, DIR_UP));
		directed.push_back(mk_call(1, 0, KIND_NONE, 0, 0, 0, 3, 0, DIR_DOWN));
		// no scan in idle or reserved direction, though calls are pending
		directed.push_back(mk_call(1, 2, KIND_HALL_UP, 0, 0, 0, 1, 0, DIR_IDLE));
		directed.push_back(mk_call(0, 0, KIND_HALL_UP, 0, 0, 0, 2, 1, DIR_RSVD));
		// single clear runs before the order, so an order on the same floor survives
		directed.push_back(mk_call(1, 2, KIND_HALL_DN, 1, 2, 0, 3, 0, DIR_DOWN));
		directed.push_back(mk_call(0, 0, KIND_HALL_UP, 1, 3, 0, 0, 0, DIR_UP));
		// full clear runs before the order in the same item
		directed.push_back(mk_call(1, 1, KIND_HALL_DN, 0, 0, 1, 3, 1, DIR_DOWN));
		// fill both sets, then scan from every last floor
		directed.push_back(mk_call(1, 2, KIND_HALL_UP, 0, 0, 0, 0, 0, DIR_UP));
		directed.push_back(mk_call(1, 3, KIND_CABIN, 0, 0, 0, 1, 1, DIR_UP));
		directed.push_back(mk_call(1, 0, KIND_CABIN, 0, 0, 0, 2, 0, DIR_DOWN));
		directed.push_back(mk_call(0, 0, KIND_HALL_UP, 0, 0, 0, 3, 1, DIR_UP));
		directed.push_back(mk_call(0, 0, KIND_HALL_UP, 0, 0, 0, 0, 0, DIR_DOWN));
		directed.push_back(mk_call(1, 1, KIND_HALL_UP, 1, 2, 0, 2, 0, DIR_UP));
		foreach (directed[i]) begin
			issue_call(directed[i]);
			hold_off(pick_gap());
		end

		// Hold the sender until every target is back before the random part.
		drain();

		// Random part: windows of steady traffic every so often, the odd full drain.
		for (n = 0; n < RANDOM_CALLS; n++) begin
			if (n % 200 == 100)
				steady <= 1'b1;
			else if (n % 200 == 140)
				steady <= 1'b0;
			issue_call(random_call());
			if ($urandom_range(0, 99) == 0)
				drain();
			else
				hold_off(steady ? 0 : pick_gap());
		end
		req_ch.valid <= 1'b0;
		steady       <= 1'b0;

		// Wait for the last targets, then give stray results time to show.
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d requests sent, %0d targets checked, %0d with a stop found",
			sent_count, checked_count, found_count);
		$display("summary: directed order kinds, clears and scans, then random traffic");
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
